[src/arm_data_processing_execute_top_defines.svh]
// assertion macros for the arm data-processing execute block
// expects clk_i and rst_ni in the scope of each use
`ifndef ARM_DATA_PROCESSING_EXECUTE_TOP_DEFINES_SVH
`define ARM_DATA_PROCESSING_EXECUTE_TOP_DEFINES_SVH

// checked at every clock edge outside reset
`define ADPE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every clock edge, reset included
`define ADPE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[src/adpe_pkg.sv]
// shared types and constants for the arm data-processing execute block
// no dependencies
package adpe_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned FlagW = 4;
  localparam int unsigned RegW  = 4;

  localparam logic [RegW-1:0]  RegPc    = 4'hF;
  localparam logic [WordW-1:0] PcOffset = 32'd8;

  // data-processing opcodes, instruction bits 24..21
  typedef enum logic [3:0] {
    OP_AND = 4'h0,
    OP_EOR = 4'h1,
    OP_SUB = 4'h2,
    OP_RSB = 4'h3,
    OP_ADD = 4'h4,
    OP_ADC = 4'h5,
    OP_SBC = 4'h6,
    OP_RSC = 4'h7,
    OP_TST = 4'h8,
    OP_TEQ = 4'h9,
    OP_CMP = 4'hA,
    OP_CMN = 4'hB,
    OP_ORR = 4'hC,
    OP_MOV = 4'hD,
    OP_BIC = 4'hE,
    OP_MVN = 4'hF
  } adpe_opcode_e;

  // condition codes, instruction bits 31..28
  typedef enum logic [3:0] {
    CC_EQ = 4'h0,
    CC_NE = 4'h1,
    CC_CS = 4'h2,
    CC_CC = 4'h3,
    CC_MI = 4'h4,
    CC_PL = 4'h5,
    CC_VS = 4'h6,
    CC_VC = 4'h7,
    CC_HI = 4'h8,
    CC_LS = 4'h9,
    CC_GE = 4'hA,
    CC_LT = 4'hB,
    CC_GT = 4'hC,
    CC_LE = 4'hD,
    CC_AL = 4'hE,
    CC_NV = 4'hF
  } adpe_cond_e;

  // immediate shift kinds, instruction bits 6..5
  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } adpe_shift_e;

  // item outcome
  typedef enum logic [1:0] {
    ST_HANDLED     = 2'd0,
    ST_NOT_DP      = 2'd1,
    ST_UNSUPPORTED = 2'd2
  } adpe_status_e;

  // item operation
  typedef enum logic {
    OPER_EXECUTE    = 1'b0,
    OPER_LOAD_FLAGS = 1'b1
  } adpe_oper_e;

  // one input beat
  typedef struct packed {
    adpe_oper_e       operation;
    logic [WordW-1:0] instruction;
    logic [WordW-1:0] pc;
    logic [WordW-1:0] first_operand;
    logic [WordW-1:0] second_operand;
    logic [WordW-1:0] status_word;
  } adpe_item_t;

  // second operand and shifter carry
  typedef struct packed {
    logic [WordW-1:0] value;
    logic             carry;
  } adpe_shift_t;

  // one result beat
  typedef struct packed {
    logic [WordW-1:0] result_value;
    logic [RegW-1:0]  dest_index;
    logic             write_dest;
    logic             writes_pc;
    logic             executed;
    adpe_status_e     status;
    logic [FlagW-1:0] flags_out;
  } adpe_result_t;

endpackage

[src/adpe_shifter.sv]
// operand-2 barrel shifter: rotated immediate or immediate-shifted register
// depends on adpe_pkg
module adpe_shifter (
  input  logic [adpe_pkg::WordW-1:0] instruction_i,
  input  logic [adpe_pkg::WordW-1:0] pc_i,
  input  logic [adpe_pkg::WordW-1:0] rm_value_i,
  input  logic                       carry_i,
  output adpe_pkg::adpe_shift_t      shift_o
);

  logic [2*adpe_pkg::WordW-1:0] imm_rot;
  logic [4:0]                   rot_amt;
  logic [adpe_pkg::WordW-1:0]   rm_val;
  logic [4:0]                   amt;
  logic [adpe_pkg::WordW:0]     lsl_w;
  logic [adpe_pkg::WordW:0]     lsr_w;
  logic signed [adpe_pkg::WordW:0] asr_w;
  logic [2*adpe_pkg::WordW-1:0] ror_w;
  adpe_pkg::adpe_shift_e        kind;

  // immediate: 8 bits rotated right by twice the rotate field
  assign rot_amt = {instruction_i[11:8], 1'b0};
  assign imm_rot = {24'd0, instruction_i[7:0], 24'd0, instruction_i[7:0]} >> rot_amt;

  // register operand, pc reads ahead by 8
  assign rm_val = (instruction_i[3:0] == adpe_pkg::RegPc) ? pc_i + adpe_pkg::PcOffset
                                                          : rm_value_i;
  assign amt   = instruction_i[11:7];
  assign kind  = adpe_pkg::adpe_shift_e'(instruction_i[6:5]);
  assign lsl_w = {1'b0, rm_val} << amt;
  assign lsr_w = {rm_val, 1'b0} >> amt;
  assign asr_w = $signed({rm_val, 1'b0}) >>> amt;
  assign ror_w = {rm_val, rm_val} >> amt;

  // select form and carry out
  always_comb begin
    shift_o = '0;
    if (instruction_i[25]) begin
      shift_o.value = imm_rot[adpe_pkg::WordW-1:0];
      shift_o.carry = (rot_amt == 5'd0) ? carry_i : imm_rot[adpe_pkg::WordW-1];
    end else begin
      case (kind)
        adpe_pkg::SH_LSL: begin
          shift_o.value = lsl_w[adpe_pkg::WordW-1:0];
          shift_o.carry = (amt == 5'd0) ? carry_i : lsl_w[adpe_pkg::WordW];
        end
        adpe_pkg::SH_LSR: begin
          if (amt == 5'd0) begin
            shift_o.value = '0;
            shift_o.carry = rm_val[adpe_pkg::WordW-1];
          end else begin
            shift_o.value = lsr_w[adpe_pkg::WordW:1];
            shift_o.carry = lsr_w[0];
          end
        end
        adpe_pkg::SH_ASR: begin
          if (amt == 5'd0) begin
            shift_o.value = {adpe_pkg::WordW{rm_val[adpe_pkg::WordW-1]}};
            shift_o.carry = rm_val[adpe_pkg::WordW-1];
          end else begin
            shift_o.value = asr_w[adpe_pkg::WordW:1];
            shift_o.carry = asr_w[0];
          end
        end
        adpe_pkg::SH_ROR: begin
          // zero amount is rrx through the kept carry
          if (amt == 5'd0) begin
            shift_o.value = {carry_i, rm_val[adpe_pkg::WordW-1:1]};
            shift_o.carry = rm_val[0];
          end else begin
            shift_o.value = ror_w[adpe_pkg::WordW-1:0];
            shift_o.carry = ror_w[adpe_pkg::WordW-1];
          end
        end
        default: begin
          shift_o.value = rm_val;
          shift_o.carry = carry_i;
        end
      endcase
    end
  end

endmodule

[src/adpe_alu.sv]
// decode, condition check, alu and flag update for one item
// depends on adpe_pkg and adpe_shifter
module adpe_alu (
  input  adpe_pkg::adpe_item_t            item_i,
  input  logic [adpe_pkg::FlagW-1:0]      flags_i,
  output adpe_pkg::adpe_result_t          result_o
);

  logic [adpe_pkg::WordW-1:0] w;
  adpe_pkg::adpe_opcode_e     opc;
  adpe_pkg::adpe_cond_e       cond;
  logic                       s_bit;
  logic                       imm_form;
  logic                       is_dp;
  logic                       unsupported;
  logic                       cond_ok;
  logic                       fn, fz, fc, fv;
  adpe_pkg::adpe_shift_t      sh;
  logic [adpe_pkg::WordW-1:0] a_val;
  logic [adpe_pkg::WordW-1:0] add_x;
  logic [adpe_pkg::WordW-1:0] add_y;
  logic                       subtract;
  logic [adpe_pkg::WordW:0]   add_sum;
  logic [adpe_pkg::WordW-1:0] add_res;
  logic                       add_v;
  logic [adpe_pkg::WordW-1:0] logic_res;

  assign w        = item_i.instruction;
  assign opc      = adpe_pkg::adpe_opcode_e'(w[24:21]);
  assign cond     = adpe_pkg::adpe_cond_e'(w[31:28]);
  assign s_bit    = w[20];
  assign imm_form = w[25];
  assign {fn, fz, fc, fv} = flags_i;

  // instruction class checks
  assign is_dp = (w[27:26] == 2'b00) && !(!imm_form && w[7] && w[4])
              && !(!s_bit && (opc inside {adpe_pkg::OP_TST, adpe_pkg::OP_TEQ,
                                          adpe_pkg::OP_CMP, adpe_pkg::OP_CMN}));
  assign unsupported = (opc inside {adpe_pkg::OP_ADC, adpe_pkg::OP_SBC, adpe_pkg::OP_RSC})
                    || (!imm_form && w[4]);

  // condition field against kept flags
  always_comb begin
    case (cond)
      adpe_pkg::CC_EQ: cond_ok = fz;
      adpe_pkg::CC_NE: cond_ok = !fz;
      adpe_pkg::CC_CS: cond_ok = fc;
      adpe_pkg::CC_CC: cond_ok = !fc;
      adpe_pkg::CC_MI: cond_ok = fn;
      adpe_pkg::CC_PL: cond_ok = !fn;
      adpe_pkg::CC_VS: cond_ok = fv;
      adpe_pkg::CC_VC: cond_ok = !fv;
      adpe_pkg::CC_HI: cond_ok = fc && !fz;
      adpe_pkg::CC_LS: cond_ok = !fc || fz;
      adpe_pkg::CC_GE: cond_ok = (fn == fv);
      adpe_pkg::CC_LT: cond_ok = (fn != fv);
      adpe_pkg::CC_GT: cond_ok = !fz && (fn == fv);
      adpe_pkg::CC_LE: cond_ok = fz || (fn != fv);
      adpe_pkg::CC_AL: cond_ok = 1'b1;
      default:         cond_ok = 1'b0;
    endcase
  end

  // second operand
  adpe_shifter u_shifter (
    .instruction_i (w),
    .pc_i          (item_i.pc),
    .rm_value_i    (item_i.second_operand),
    .carry_i       (fc),
    .shift_o       (sh)
  );

  assign a_val = (w[19:16] == adpe_pkg::RegPc) ? item_i.pc + adpe_pkg::PcOffset
                                               : item_i.first_operand;

  // shared adder: subtraction adds the inverted operand plus one
  assign subtract = (opc == adpe_pkg::OP_SUB) || (opc == adpe_pkg::OP_RSB)
                 || (opc == adpe_pkg::OP_CMP);
  assign add_x    = (opc == adpe_pkg::OP_RSB) ? sh.value : a_val;
  assign add_y    = ((opc == adpe_pkg::OP_RSB) ? a_val : sh.value)
                    ^ {adpe_pkg::WordW{subtract}};
  assign add_sum  = {1'b0, add_x} + {1'b0, add_y}
                    + {{adpe_pkg::WordW{1'b0}}, subtract};
  assign add_res  = add_sum[adpe_pkg::WordW-1:0];
  assign add_v    = ~(add_x[adpe_pkg::WordW-1] ^ add_y[adpe_pkg::WordW-1])
                    & (add_x[adpe_pkg::WordW-1] ^ add_res[adpe_pkg::WordW-1]);

  // logical unit
  always_comb begin
    case (opc)
      adpe_pkg::OP_AND, adpe_pkg::OP_TST: logic_res = a_val & sh.value;
      adpe_pkg::OP_EOR, adpe_pkg::OP_TEQ: logic_res = a_val ^ sh.value;
      adpe_pkg::OP_ORR:                   logic_res = a_val | sh.value;
      adpe_pkg::OP_MOV:                   logic_res = sh.value;
      adpe_pkg::OP_BIC:                   logic_res = a_val & ~sh.value;
      default:                            logic_res = ~sh.value;
    endcase
  end

  // result beat and next flags
  always_comb begin
    logic                       arith;
    logic [adpe_pkg::WordW-1:0] res;
    logic                       wr;
    arith = opc inside {adpe_pkg::OP_SUB, adpe_pkg::OP_RSB, adpe_pkg::OP_ADD,
                        adpe_pkg::OP_CMP, adpe_pkg::OP_CMN};
    res   = arith ? add_res : logic_res;
    wr    = !(opc inside {adpe_pkg::OP_TST, adpe_pkg::OP_TEQ,
                          adpe_pkg::OP_CMP, adpe_pkg::OP_CMN});

    result_o            = '0;
    result_o.status     = adpe_pkg::ST_HANDLED;
    result_o.flags_out  = flags_i;
    if (item_i.operation == adpe_pkg::OPER_LOAD_FLAGS) begin
      result_o.flags_out = item_i.status_word[adpe_pkg::WordW-1 -: adpe_pkg::FlagW];
    end else begin
      result_o.dest_index = w[15:12];
      if (!is_dp) begin
        result_o.status = adpe_pkg::ST_NOT_DP;
      end else if (unsupported) begin
        result_o.status = adpe_pkg::ST_UNSUPPORTED;
      end else if (cond_ok) begin
        result_o.executed     = 1'b1;
        result_o.result_value = res;
        result_o.write_dest   = wr;
        result_o.writes_pc    = wr && (w[15:12] == adpe_pkg::RegPc);
        // compares always set flags, the rest only with s
        if (s_bit || !wr) begin
          if (arith) begin
            result_o.flags_out = {res[adpe_pkg::WordW-1], (res == '0),
                                  add_sum[adpe_pkg::WordW], add_v};
          end else begin
            result_o.flags_out = {res[adpe_pkg::WordW-1], (res == '0), sh.carry, fv};
          end
        end
      end
    end
  end

endmodule

[src/arm_data_processing_execute_top.sv]
// top level of the arm data-processing execute block: input and result registers
// depends on adpe_pkg, adpe_alu and the assertion macro header
//
//  channel   dir  beat carries
//  s_axis    in   tuser: operation; tdata: instruction, pc, first/second operand,
//                 status word
//  m_axis    out  tdata: result value, dest index, write dest, writes pc,
//                 executed, status, flags
//
// one beat per cycle sustained while m_axis is ready; a beat is held in the input register
// and then in the result register, from which it appears on m_axis
// the flag register updates as a beat moves into the result register, so the
// next beat in the input register already sees the new flags
// reset clears both valid bits and the flags; m_axis stalls back up through
// the result register into the input register and then into s_axis tready
`include "arm_data_processing_execute_top_defines.svh"

module arm_data_processing_execute_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // bits 31..0 instruction, 63..32 pc, 95..64 first_operand,
  // 127..96 second_operand, 159..128 status_word
  input  logic [159:0] s_axis_tdata_i,
  // bit 0 operation
  input  logic [0:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // bits 31..0 result_value, 35..32 dest_index, 36 write_dest, 37 writes_pc,
  // 38 executed, 40..39 status, 44..41 flags_out, 47..45 zero
  output logic [47:0]  m_axis_tdata_o
);

  adpe_pkg::adpe_item_t            item_q;
  logic                            in_valid_q;
  adpe_pkg::adpe_result_t          out_q;
  logic                            out_valid_q;
  logic [adpe_pkg::FlagW-1:0]      flags_q;
  logic [adpe_pkg::FlagW-1:0]      flags_d;
  adpe_pkg::adpe_result_t          alu_res;
  logic                            take_in;
  logic                            advance;

  // handshakes
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || !out_valid_q || m_axis_tready_i;
  assign take_in         = s_axis_tvalid_i && s_axis_tready_o;

  // input register, control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (take_in) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // input register, payload
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      item_q.operation      <= adpe_pkg::adpe_oper_e'(s_axis_tuser_i[0]);
      item_q.instruction    <= s_axis_tdata_i[31:0];
      item_q.pc             <= s_axis_tdata_i[63:32];
      item_q.first_operand  <= s_axis_tdata_i[95:64];
      item_q.second_operand <= s_axis_tdata_i[127:96];
      item_q.status_word    <= s_axis_tdata_i[159:128];
    end
  end

  adpe_alu u_alu (
    .item_i   (item_q),
    .flags_i  (flags_q),
    .result_o (alu_res)
  );

  assign flags_d = advance ? alu_res.flags_out : flags_q;

  // kept flags and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      flags_q <= flags_d;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register, payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= alu_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_q.flags_out, out_q.status, out_q.executed,
                            out_q.writes_pc, out_q.write_dest, out_q.dest_index,
                            out_q.result_value};

  // assertions
  `ADPE_ASSERT(a_flags_only_on_advance, !advance |=> $stable(flags_q), "flags changed with no beat moving")
  `ADPE_ASSERT(a_out_flags_match, out_valid_q |-> (out_q.flags_out == flags_q), "result flags differ from kept flags")
  `ADPE_ASSERT(a_write_needs_exec, out_valid_q && out_q.write_dest |-> out_q.executed, "destination write without execution")
  `ADPE_ASSERT(a_error_not_exec, out_valid_q && (out_q.status != adpe_pkg::ST_HANDLED) |-> !out_q.executed, "faulted beat marked executed")
  `ADPE_ASSERT(a_pc_write_dest, out_valid_q && out_q.writes_pc |-> out_q.write_dest && (out_q.dest_index == adpe_pkg::RegPc), "pc write flag without a write to register 15")
  `ADPE_ASSERT_ALWAYS(a_reset_clears, !rst_ni |=> !in_valid_q && !out_valid_q, "valid bits set during reset")

endmodule
